// File: src/pfk_pkg.sv
// Shared widths, register codes and pipeline tag types for the pair force kernel.
package pfk_pkg;

	// Field widths
	localparam int POS_W   = 28;
	localparam int K_W     = 24;
	localparam int RANGE_W = 20;
	localparam int GAIN_W  = 24;
	localparam int COL_W   = 2;
	localparam int FORCE_W = 32;
	localparam int CFG_W   = 28;
	localparam int IDX_W   = 3;

	// Datapath widths
	localparam int DIF_W  = POS_W + 1;      // wrapped separation, signed
	localparam int SQ_W   = 2 * POS_W;      // square of one separation magnitude
	localparam int D2_W   = SQ_W + 1;       // squared distance
	localparam int RAD_W  = D2_W + 1;       // radicand padded to an even width
	localparam int ROOT_W = RAD_W / 2;      // integer distance
	localparam int P_W    = GAIN_W + DIF_W; // gain times separation, signed
	localparam int NUM_W  = K_W + ROOT_W;   // dividend; also holds 2^(2F) for F up to 24
	localparam int MW     = 64;             // magnitude width of the force law products
	localparam int RSQ_W  = 2 * RANGE_W;

	localparam int DEF_FRAC_BITS = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_REGION = 3'd0;
	localparam logic [IDX_W-1:0] REG_K      = 3'd1;
	localparam logic [IDX_W-1:0] REG_RANGE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_LJ     = 3'd3;
	localparam logic [IDX_W-1:0] REG_RR     = 3'd4;
	localparam logic [IDX_W-1:0] REG_GG     = 3'd5;
	localparam logic [IDX_W-1:0] REG_RG     = 3'd6;

	// Colour codes
	localparam logic [COL_W-1:0] COL_RED    = 2'd0;
	localparam logic [COL_W-1:0] COL_GREEN  = 2'd1;
	localparam logic [COL_W-1:0] COL_PGREEN = 2'd2;

	// Reset values
	localparam logic [POS_W-1:0]          RST_REGION = 28'd2097152;
	localparam logic [K_W-1:0]            RST_K      = 24'd65536;
	localparam logic [RANGE_W-1:0]        RST_RANGE  = 20'd98304;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN   = 24'sd65536;

	// Geometry after the distance stage
	typedef struct packed {
		logic signed [P_W-1:0] px;
		logic signed [P_W-1:0] py;
		logic                  touch;
		logic                  active;
		logic                  zero;
	} geo_t;

	// Per-pair data carried alongside the divider
	typedef struct packed {
		logic [P_W-1:0] pxm;
		logic [P_W-1:0] pym;
		logic           negx;
		logic           negy;
		logic           hneg;
		logic           touch;
		logic           active;
		logic           zero;
	} frc_t;

	// Carried through the Lennard-Jones product chain
	typedef struct packed {
		frc_t             f;
		logic [NUM_W-1:0] hmag;
		logic [MW-1:0]    i2;
		logic [MW-1:0]    t;
		logic             tneg;
		logic             sat;
	} lj_t;

	// Carried through the final force products
	typedef struct packed {
		logic negx;
		logic negy;
		logic touch;
		logic active;
		logic zero;
		logic ljsat;
	} fin_t;

	// One result beat
	typedef struct packed {
		logic [FORCE_W-1:0] fx;
		logic [FORCE_W-1:0] fy;
		logic               touching;
		logic               in_range;
		logic               saturated;
	} res_t;

endpackage

// File: src/pfk_sqrt.sv
// Pipelined integer square root, a few result bits per stage.
module pfk_sqrt #(
	parameter int IN_W  = pfk_pkg::RAD_W,
	parameter int TAG_W = 1,
	parameter int BPS   = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic [IN_W-1:0]     rad_i,
	input  logic [TAG_W-1:0]    tag_i,
	output logic                vld_o,
	output logic [IN_W/2-1:0]   root_o,
	output logic [TAG_W-1:0]    tag_o
);
	localparam int R_W   = IN_W / 2;
	localparam int NST   = (R_W + BPS - 1) / BPS;
	localparam int REM_W = R_W + 2;

	logic             vld_s  [1:NST];
	logic [IN_W-1:0]  rad_s  [1:NST];
	logic [REM_W-1:0] rem_s  [1:NST];
	logic [R_W-1:0]   root_s [1:NST];
	logic [TAG_W-1:0] tag_s  [1:NST];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic             vld_c;
		logic [IN_W-1:0]  rad_c;
		logic [REM_W-1:0] rem_c;
		logic [R_W-1:0]   root_c;
		logic [TAG_W-1:0] tag_c;
		logic [REM_W-1:0] rem_n;
		logic [R_W-1:0]   root_n;

		if (s == 0) begin : g_in
			assign vld_c  = vld_i;
			assign rad_c  = rad_i;
			assign rem_c  = '0;
			assign root_c = '0;
			assign tag_c  = tag_i;
		end else begin : g_mid
			assign vld_c  = vld_s[s];
			assign rad_c  = rad_s[s];
			assign rem_c  = rem_s[s];
			assign root_c = root_s[s];
			assign tag_c  = tag_s[s];
		end

		// digit recurrence: bring down two radicand bits, try (root<<2)|1
		always_comb begin
			logic [REM_W+1:0] acc;
			logic [REM_W+1:0] trial;
			rem_n  = rem_c;
			root_n = root_c;
			acc    = '0;
			trial  = '0;
			for (int k = 0; k < BPS; k++) begin
				if (s * BPS + k < R_W) begin
					acc   = {rem_n, rad_c[IN_W-1-2*(s*BPS+k) -: 2]};
					trial = (REM_W+2)'({root_n, 2'b01});
					if (acc >= trial) begin
						acc    = acc - trial;
						root_n = {root_n[R_W-2:0], 1'b1};
					end else begin
						root_n = {root_n[R_W-2:0], 1'b0};
					end
					rem_n = acc[REM_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[s+1]  <= rad_c;
				rem_s[s+1]  <= rem_n;
				root_s[s+1] <= root_n;
				tag_s[s+1]  <= tag_c;
			end
		end
	end

	assign vld_o  = vld_s[NST];
	assign root_o = root_s[NST];
	assign tag_o  = tag_s[NST];

endmodule

// File: src/pfk_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
module pfk_div #(
	parameter int N_W   = pfk_pkg::NUM_W,
	parameter int D_W   = pfk_pkg::ROOT_W,
	parameter int TAG_W = 1,
	parameter int BPS   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  logic [N_W-1:0]   num_i,
	input  logic [D_W-1:0]   den_i,
	input  logic [TAG_W-1:0] tag_i,
	output logic             vld_o,
	output logic [N_W-1:0]   quo_o,
	output logic [TAG_W-1:0] tag_o
);
	localparam int NST = (N_W + BPS - 1) / BPS;

	logic             vld_s [1:NST];
	logic [N_W-1:0]   num_s [1:NST];
	logic [D_W-1:0]   den_s [1:NST];
	logic [D_W-1:0]   rem_s [1:NST];
	logic [N_W-1:0]   quo_s [1:NST];
	logic [TAG_W-1:0] tag_s [1:NST];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic             vld_c;
		logic [N_W-1:0]   num_c;
		logic [D_W-1:0]   den_c;
		logic [D_W-1:0]   rem_c;
		logic [N_W-1:0]   quo_c;
		logic [TAG_W-1:0] tag_c;
		logic [D_W-1:0]   rem_n;
		logic [N_W-1:0]   quo_n;

		if (s == 0) begin : g_in
			assign vld_c = vld_i;
			assign num_c = num_i;
			assign den_c = den_i;
			assign rem_c = '0;
			assign quo_c = '0;
			assign tag_c = tag_i;
		end else begin : g_mid
			assign vld_c = vld_s[s];
			assign num_c = num_s[s];
			assign den_c = den_s[s];
			assign rem_c = rem_s[s];
			assign quo_c = quo_s[s];
			assign tag_c = tag_s[s];
		end

		// shift in one dividend bit, subtract the divisor when it fits
		always_comb begin
			logic [D_W:0] acc;
			rem_n = rem_c;
			quo_n = quo_c;
			acc   = '0;
			for (int k = 0; k < BPS; k++) begin
				if (s * BPS + k < N_W) begin
					acc = {rem_n, num_c[N_W-1-(s*BPS+k)]};
					if (acc >= {1'b0, den_c}) begin
						acc   = acc - {1'b0, den_c};
						quo_n = {quo_n[N_W-2:0], 1'b1};
					end else begin
						quo_n = {quo_n[N_W-2:0], 1'b0};
					end
					rem_n = acc[D_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[s+1] <= num_c;
				den_s[s+1] <= den_c;
				rem_s[s+1] <= rem_n;
				quo_s[s+1] <= quo_n;
				tag_s[s+1] <= tag_c;
			end
		end
	end

	assign vld_o = vld_s[NST];
	assign quo_o = quo_s[NST];
	assign tag_o = tag_s[NST];

endmodule

// File: src/pfk_mulshr.sv
// Three-stage 64x64 multiply, right shift and clip to 64 bits.
module pfk_mulshr #(
	parameter int SHIFT = pfk_pkg::DEF_FRAC_BITS,
	parameter int TAG_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  logic [pfk_pkg::MW-1:0] a_i,
	input  logic [pfk_pkg::MW-1:0] b_i,
	input  logic [TAG_W-1:0]      tag_i,
	output logic                  vld_o,
	output logic [pfk_pkg::MW-1:0] r_o,
	output logic                  sat_o,
	output logic [TAG_W-1:0]      tag_o
);
	import pfk_pkg::*;

	localparam int H  = MW / 2;
	localparam int PW = 2 * MW;

	logic            vld_s1, vld_s2, vld_s3;
	logic [MW-1:0]   p00_s1, p01_s1, p10_s1, p11_s1;
	logic [PW-1:0]   prod_s2;
	logic [MW-1:0]   r_s3;
	logic            sat_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic            sat_c;

	assign sat_c = |prod_s2[PW-1:MW+SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// partial products, then their sum, then shift and clip
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a_i[H-1:0] * b_i[H-1:0];
			p01_s1  <= a_i[H-1:0] * b_i[MW-1:H];
			p10_s1  <= a_i[MW-1:H] * b_i[H-1:0];
			p11_s1  <= a_i[MW-1:H] * b_i[MW-1:H];
			tag_s1  <= tag_i;
			prod_s2 <= PW'(p00_s1) + (PW'(p01_s1) << H) + (PW'(p10_s1) << H)
				+ {p11_s1, {MW{1'b0}}};
			tag_s2  <= tag_s1;
			sat_s3  <= sat_c;
			r_s3    <= sat_c ? {MW{1'b1}} : prod_s2[SHIFT+MW-1:SHIFT];
			tag_s3  <= tag_s2;
		end
	end

	assign vld_o = vld_s3;
	assign r_o   = r_s3;
	assign sat_o = sat_s3;
	assign tag_o = tag_s3;

endmodule

// File: src/pair_force_kernel.sv
// Pair force kernel: minimum-image separation, distance and force law for one pair per beat.
//
// Usage: pairs enter on pair_valid/pair_ready; each beat carries two positions (unsigned
// Q12.F) and two colour codes. One result beat leaves on force_valid/force_ready with the
// force on the first particle (signed Q16.F, saturated) and the touching, in_range and
// saturated flags. The caller applies the negated force to the second particle.
// Registers are written through cfg_wen/cfg_index/cfg_data, one per cycle, while no pair
// is in flight; an unknown index is ignored.
// From pair accept to force_valid at the default widths a pair passes three
// separation/distance stages, 8 square-root stages, one prepare stage, 14 divider stages,
// five chained 3-stage products of the Lennard-Jones law, a 3-stage force product and
// the output register. The square root and the divider retire four bits a stage.
// Throughput is one pair per cycle while pair_ready is high; every stage is pipelined.
// Reset clears all valid bits and loads the register defaults (box 32.0, k 1.0,
// range 1.5, harmonic, all gains 1.0).
// When force_ready is low the finished beat waits in the output register, one more beat
// lands in a skid register, and only then pair_ready drops and the whole pipe holds.
module pair_force_kernel #(
	parameter int FRAC_BITS = pfk_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [pfk_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pfk_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             pair_valid,
	output logic                             pair_ready,
	input  logic [pfk_pkg::POS_W-1:0]        first_x,
	input  logic [pfk_pkg::POS_W-1:0]        first_y,
	input  logic [pfk_pkg::POS_W-1:0]        second_x,
	input  logic [pfk_pkg::POS_W-1:0]        second_y,
	input  logic [pfk_pkg::COL_W-1:0]        first_color,
	input  logic [pfk_pkg::COL_W-1:0]        second_color,
	output logic                             force_valid,
	input  logic                             force_ready,
	output logic signed [pfk_pkg::FORCE_W-1:0] force_x,
	output logic signed [pfk_pkg::FORCE_W-1:0] force_y,
	output logic                             touching,
	output logic                             in_range,
	output logic                             saturated
);
	import pfk_pkg::*;

	// ---------------- configuration registers ----------------
	logic [POS_W-1:0]         region_q;
	logic [K_W-1:0]           spring_k_q;
	logic [RANGE_W-1:0]       range_q;
	logic                     lj_q;
	logic signed [GAIN_W-1:0] rr_gain_q, gg_gain_q, rg_gain_q;
	logic [RSQ_W-1:0]         range_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q   <= RST_REGION;
			spring_k_q <= RST_K;
			range_q    <= RST_RANGE;
			lj_q       <= 1'b0;
			rr_gain_q  <= RST_GAIN;
			gg_gain_q  <= RST_GAIN;
			rg_gain_q  <= RST_GAIN;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_REGION: region_q   <= cfg_data[POS_W-1:0];
				REG_K:      spring_k_q <= cfg_data[K_W-1:0];
				REG_RANGE:  range_q    <= cfg_data[RANGE_W-1:0];
				REG_LJ:     lj_q       <= cfg_data[0];
				REG_RR:     rr_gain_q  <= signed'(cfg_data[GAIN_W-1:0]);
				REG_GG:     gg_gain_q  <= signed'(cfg_data[GAIN_W-1:0]);
				REG_RG:     rg_gain_q  <= signed'(cfg_data[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	// cutoff squared, registered; follows the range register in the next cycle
	always_ff @(posedge clk) begin
		range_sq_q <= RSQ_W'(range_q) * RSQ_W'(range_q);
	end

	// ---------------- pipeline advance ----------------
	logic en;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	assign en         = !skid_v_q;
	assign pair_ready = en;

	// single minimum-image wrap on one axis
	function automatic logic signed [DIF_W-1:0] wrap_axis(
		input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b,
		input logic [POS_W-1:0] len
	);
		logic signed [DIF_W+1:0] d;
		logic signed [DIF_W+1:0] two;
		logic signed [DIF_W+1:0] l;
		d   = signed'({3'b000, a}) - signed'({3'b000, b});
		two = d <<< 1;
		l   = signed'({3'b000, len});
		if (two >= l) begin
			d = d - l;
		end else if (two < -l) begin
			d = d + l;
		end
		return d[DIF_W-1:0];
	endfunction

	// ---------------- stage 1: wrap and gain select ----------------
	logic                     vld_s1;
	logic signed [DIF_W-1:0]  dx_s1, dy_s1;
	logic signed [GAIN_W-1:0] gain_s1;
	logic signed [GAIN_W-1:0] gain_c;

	always_comb begin
		if (first_color == COL_RED && second_color == COL_RED) begin
			gain_c = rr_gain_q;
		end else if ((first_color inside {COL_GREEN, COL_PGREEN})
				&& (second_color inside {COL_GREEN, COL_PGREEN})) begin
			gain_c = gg_gain_q;
		end else begin
			gain_c = rg_gain_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= wrap_axis(first_x, second_x, region_q);
			dy_s1   <= wrap_axis(first_y, second_y, region_q);
			gain_s1 <= gain_c;
		end
	end

	// ---------------- stage 2: squares and gain products ----------------
	logic                    vld_s2;
	logic [SQ_W-1:0]         sqx_s2, sqy_s2;
	logic signed [P_W-1:0]   gpx_s2, gpy_s2;
	logic signed [DIF_W-1:0] dx_s2, dy_s2;
	logic [DIF_W-1:0]        ax_c, ay_c;

	assign ax_c = dx_s1[DIF_W-1] ? DIF_W'(-dx_s1) : DIF_W'(dx_s1);
	assign ay_c = dy_s1[DIF_W-1] ? DIF_W'(-dy_s1) : DIF_W'(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= SQ_W'(ax_c[POS_W-1:0]) * SQ_W'(ax_c[POS_W-1:0]);
			sqy_s2 <= SQ_W'(ay_c[POS_W-1:0]) * SQ_W'(ay_c[POS_W-1:0]);
			gpx_s2 <= P_W'(gain_s1) * P_W'(dx_s1);
			gpy_s2 <= P_W'(gain_s1) * P_W'(dy_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
		end
	end

	// ---------------- stage 3: distance squared and classification ----------------
	logic             vld_s3;
	logic [D2_W-1:0]  d2_s3;
	geo_t             geo_s3;
	logic [D2_W-1:0]  d2_c;
	geo_t             geo_c;

	always_comb begin
		d2_c         = D2_W'(sqx_s2) + D2_W'(sqy_s2);
		geo_c.zero   = (d2_c == '0);
		geo_c.touch  = d2_c < (D2_W'(1) << (2 * FRAC_BITS));
		geo_c.active = !geo_c.zero && (geo_c.touch || (d2_c < D2_W'(range_sq_q)));
		// touching pairs use a gain of exactly one
		geo_c.px     = geo_c.touch ? (P_W'(dx_s2) <<< FRAC_BITS) : gpx_s2;
		geo_c.py     = geo_c.touch ? (P_W'(dy_s2) <<< FRAC_BITS) : gpy_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3  <= d2_c;
			geo_s3 <= geo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// ---------------- square root ----------------
	logic              vld_r;
	logic [ROOT_W-1:0] root_r;
	geo_t              geo_r;

	pfk_sqrt #(
		.IN_W  (RAD_W),
		.TAG_W ($bits(geo_t))
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.rad_i  ({1'b0, d2_s3}),
		.tag_i  (geo_s3),
		.vld_o  (vld_r),
		.root_o (root_r),
		.tag_o  (geo_r)
	);

	// ---------------- stage 4: dividend and magnitudes ----------------
	logic              vld_s4;
	logic [NUM_W-1:0]  num_s4;
	logic [ROOT_W-1:0] den_s4;
	frc_t              frc_s4;
	logic [ROOT_W-1:0] one_r;
	logic [ROOT_W-1:0] hd_c;
	frc_t              frc_c;

	assign one_r = ROOT_W'(1) << FRAC_BITS;

	always_comb begin
		frc_c.hneg   = root_r > one_r;
		hd_c         = frc_c.hneg ? (root_r - one_r) : (one_r - root_r);
		frc_c.negx   = geo_r.px[P_W-1];
		frc_c.negy   = geo_r.py[P_W-1];
		frc_c.pxm    = geo_r.px[P_W-1] ? P_W'(-geo_r.px) : P_W'(geo_r.px);
		frc_c.pym    = geo_r.py[P_W-1] ? P_W'(-geo_r.py) : P_W'(geo_r.py);
		frc_c.touch  = geo_r.touch;
		frc_c.active = geo_r.active;
		frc_c.zero   = geo_r.zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= lj_q ? (NUM_W'(1) << (2 * FRAC_BITS))
				: NUM_W'(spring_k_q) * NUM_W'(hd_c);
			den_s4 <= root_r;
			frc_s4 <= frc_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_r;
		end
	end

	// ---------------- divider: k|1-d|/d or 2^(2F)/d ----------------
	logic             vld_d;
	logic [NUM_W-1:0] quo_d;
	frc_t             frc_d;

	pfk_div #(
		.N_W   (NUM_W),
		.D_W   (ROOT_W),
		.TAG_W ($bits(frc_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.num_i  (num_s4),
		.den_i  (den_s4),
		.tag_i  (frc_s4),
		.vld_o  (vld_d),
		.quo_o  (quo_d),
		.tag_o  (frc_d)
	);

	// ---------------- Lennard-Jones products ----------------
	logic [MW-1:0] one64;
	assign one64 = MW'(1) << FRAC_BITS;

	lj_t           tag1_i, tag1_o, tag2_i, tag2_o, tag3_i, tag3_o, tag4_i, tag4_o;
	lj_t           tag5_i, tag5_o;
	logic          vld1, vld2, vld3, vld4, vld5;
	logic [MW-1:0] i2_r, i4_r, i6_r, i8_r, a12_r, mlj_r;
	logic          sat1, sat2, sat3a, sat3b, sat4, sat5;

	always_comb begin
		tag1_i      = '0;
		tag1_i.f    = frc_d;
		tag1_i.hmag = quo_d;

		tag2_i      = tag1_o;
		tag2_i.i2   = i2_r;
		tag2_i.sat  = tag1_o.sat | sat1;

		tag3_i      = tag2_o;
		tag3_i.sat  = tag2_o.sat | sat2;

		tag4_i      = tag3_o;
		tag4_i.tneg = i6_r < one64;
		tag4_i.t    = tag4_i.tneg ? (one64 - i6_r) : (i6_r - one64);
		tag4_i.sat  = tag3_o.sat | sat3a | sat3b;

		tag5_i      = tag4_o;
		tag5_i.sat  = tag4_o.sat | sat4;
	end

	// inv^2
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W($bits(lj_t))) u_m1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_d),
		.a_i(MW'(quo_d)), .b_i(MW'(quo_d)), .tag_i(tag1_i),
		.vld_o(vld1), .r_o(i2_r), .sat_o(sat1), .tag_o(tag1_o)
	);

	// inv^4
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W($bits(lj_t))) u_m2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld1),
		.a_i(i2_r), .b_i(i2_r), .tag_i(tag2_i),
		.vld_o(vld2), .r_o(i4_r), .sat_o(sat2), .tag_o(tag2_o)
	);

	// inv^6
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W($bits(lj_t))) u_m3a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld2),
		.a_i(i4_r), .b_i(tag2_o.i2), .tag_i(tag3_i),
		.vld_o(vld3), .r_o(i6_r), .sat_o(sat3a), .tag_o(tag3_o)
	);

	// inv^8, runs beside inv^6
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W(1)) u_m3b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld2),
		.a_i(i4_r), .b_i(i4_r), .tag_i(1'b0),
		.vld_o(), .r_o(i8_r), .sat_o(sat3b), .tag_o()
	);

	// 12k * inv^8
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W($bits(lj_t))) u_m4 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld3),
		.a_i(MW'({spring_k_q, 3'b000}) + MW'({spring_k_q, 2'b00})), .b_i(i8_r),
		.tag_i(tag4_i),
		.vld_o(vld4), .r_o(a12_r), .sat_o(sat4), .tag_o(tag4_o)
	);

	// times |inv^6 - 1|
	pfk_mulshr #(.SHIFT(FRAC_BITS), .TAG_W($bits(lj_t))) u_m5 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld4),
		.a_i(a12_r), .b_i(tag4_o.t), .tag_i(tag5_i),
		.vld_o(vld5), .r_o(mlj_r), .sat_o(sat5), .tag_o(tag5_o)
	);

	// ---------------- force products ----------------
	logic [MW-1:0] mmag_c;
	logic          mneg_c;
	fin_t          fin_i, fin_o;
	logic          vld_f;
	logic [MW-1:0] magx_r, magy_r;
	logic          fsatx, fsaty;

	always_comb begin
		mmag_c       = lj_q ? mlj_r : MW'(tag5_o.hmag);
		mneg_c       = lj_q ? tag5_o.tneg : tag5_o.f.hneg;
		fin_i.negx   = mneg_c ^ tag5_o.f.negx;
		fin_i.negy   = mneg_c ^ tag5_o.f.negy;
		fin_i.touch  = tag5_o.f.touch;
		fin_i.active = tag5_o.f.active;
		fin_i.zero   = tag5_o.f.zero;
		fin_i.ljsat  = lj_q & (tag5_o.sat | sat5);
	end

	pfk_mulshr #(.SHIFT(2 * FRAC_BITS), .TAG_W($bits(fin_t))) u_fx (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld5),
		.a_i(mmag_c), .b_i(MW'(tag5_o.f.pxm)), .tag_i(fin_i),
		.vld_o(vld_f), .r_o(magx_r), .sat_o(fsatx), .tag_o(fin_o)
	);

	pfk_mulshr #(.SHIFT(2 * FRAC_BITS), .TAG_W(1)) u_fy (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld5),
		.a_i(mmag_c), .b_i(MW'(tag5_o.f.pym)), .tag_i(1'b0),
		.vld_o(), .r_o(magy_r), .sat_o(fsaty), .tag_o()
	);

	// signed clip to 32 bits; top bit of the result flags a clip
	function automatic logic [FORCE_W:0] clip_force(
		input logic [MW-1:0] mag,
		input logic          neg
	);
		logic [FORCE_W-1:0] v;
		logic               s;
		s = 1'b0;
		if (!neg) begin
			if (mag > MW'({1'b0, {(FORCE_W-1){1'b1}}})) begin
				s = 1'b1;
				v = {1'b0, {(FORCE_W-1){1'b1}}};
			end else begin
				v = mag[FORCE_W-1:0];
			end
		end else begin
			if (mag > MW'({1'b1, {(FORCE_W-1){1'b0}}})) begin
				s = 1'b1;
				v = {1'b1, {(FORCE_W-1){1'b0}}};
			end else begin
				v = -mag[FORCE_W-1:0];
			end
		end
		return {s, v};
	endfunction

	logic [FORCE_W:0] cx_c, cy_c;
	res_t             res_c;

	always_comb begin
		cx_c            = clip_force(magx_r, fin_o.negx);
		cy_c            = clip_force(magy_r, fin_o.negy);
		res_c.fx        = fin_o.active ? cx_c[FORCE_W-1:0] : '0;
		res_c.fy        = fin_o.active ? cy_c[FORCE_W-1:0] : '0;
		res_c.touching  = fin_o.touch;
		res_c.in_range  = fin_o.active;
		res_c.saturated = fin_o.zero | (fin_o.active & (fin_o.ljsat | fsatx | fsaty
			| cx_c[FORCE_W] | cy_c[FORCE_W]));
	end

	// ---------------- output register and skid ----------------
	logic push, fire;

	assign push = vld_f & en;
	assign fire = out_v_q & force_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (fire) begin
				out_q    <= skid_q;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || fire) begin
				out_q   <= res_c;
				out_v_q <= 1'b1;
			end else begin
				skid_q   <= res_c;
				skid_v_q <= 1'b1;
			end
		end else if (fire) begin
			out_v_q <= 1'b0;
		end
	end

	assign force_valid = out_v_q;
	assign force_x     = signed'(out_q.fx);
	assign force_y     = signed'(out_q.fy);
	assign touching    = out_q.touching;
	assign in_range    = out_q.in_range;
	assign saturated   = out_q.saturated;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a beat while the output register is empty");

	a_no_force_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(force_valid && !in_range) |-> (force_x == 0 && force_y == 0))
		else $error("nonzero force on a pair outside the force law");

	a_zero_sep_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(force_valid && !in_range && touching) |-> saturated)
		else $error("zero separation not flagged as saturated");
`endif

endmodule

// File: tb/pair_force_kernel_tb.sv
// Self-checking testbench for the pair force kernel: queued pair driver, result monitor.
module pair_force_kernel_tb;
	import pfk_pkg::*;

	localparam int FB       = DEF_FRAC_BITS;
	localparam int LIMIT    = 400000;
	localparam int SETTLE   = 60;
	localparam int LONG_OFF = 300;
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct {
		logic [POS_W-1:0] x1, y1, x2, y2;
		logic [COL_W-1:0] c1, c2;
	} pair_t;

	typedef struct {
		logic [FORCE_W-1:0] fx, fy;
		logic touch, near, sat;
	} force_res_t;

	logic clk, arst_n;
	logic cfg_wen;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic pair_valid, pair_ready;
	logic [POS_W-1:0] first_x, first_y, second_x, second_y;
	logic [COL_W-1:0] first_color, second_color;
	logic force_valid, force_ready;
	logic signed [FORCE_W-1:0] force_x, force_y;
	logic touching, in_range, saturated;

	pair_force_kernel dut (.*);

	// shadow of the block's registers
	logic [63:0] box_len, stiff, cutoff;
	logic lj_mode;
	longint gain_rr, gain_gg, gain_rg;

	pair_t pending[$];
	force_res_t expected_forces[$];
	int errors = 0;
	int cyc = 0;
	bit taken = 0;
	int send_gap = 0, recv_gap = 0;
	bit quiet = 0, want_long_off = 0, long_done = 0;
	int long_cnt = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// (a*b)>>s with magnitude clipped to 64 bits
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int s, inout bit sat);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0) begin
			sat = 1;
			return '1;
		end
		return p[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint min_image(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
		longint dx, l;
		l = longint'(box_len);
		dx = longint'({36'd0, a}) - longint'({36'd0, b});
		if (2 * dx >= l) dx = dx - l;
		else if (2 * dx < -l) dx = dx + l;
		return dx;
	endfunction

	function automatic logic [FORCE_W-1:0] axis_force(input logic [63:0] mmag, input bit mneg,
			input longint g, input longint dx, inout bit sat);
		longint p;
		bit neg;
		logic [63:0] pm, mag;
		p = g * dx;
		neg = mneg ^ (p < 0);
		pm = (p < 0) ? -p : p;
		mag = mul_shift(mmag, pm, 2 * FB, sat);
		if (!neg) begin
			if (mag > 64'h7FFFFFFF) begin
				sat = 1;
				mag = 64'h7FFFFFFF;
			end
			return mag[31:0];
		end
		if (mag > 64'h80000000) begin
			sat = 1;
			mag = 64'h80000000;
		end
		return 32'(-mag);
	endfunction

	function automatic force_res_t pair_force(input pair_t it);
		force_res_t r;
		longint dx, dy, g;
		logic [63:0] ax, ay, d2, d, one, inv, i2, i4, i6, i8, t, mmag;
		bit sat, mneg;
		one = 64'd1 << FB;
		r = '{default: 0};
		sat = 0;
		dx = min_image(it.x1, it.x2);
		dy = min_image(it.y1, it.y2);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		d2 = ax * ax + ay * ay;
		if (d2 == 0) begin
			r.touch = 1;
			r.sat = 1;
			return r;
		end
		r.touch = d2 < one * one;
		if (!r.touch && !(d2 < cutoff * cutoff)) return r;
		d = int_sqrt(d2);
		if (lj_mode) begin
			inv = (64'd1 << (2 * FB)) / d;
			i2 = mul_shift(inv, inv, FB, sat);
			i4 = mul_shift(i2, i2, FB, sat);
			i6 = mul_shift(i4, i2, FB, sat);
			i8 = mul_shift(i4, i4, FB, sat);
			mneg = i6 < one;
			t = mneg ? one - i6 : i6 - one;
			// one product per call so every clip reaches sat
			i8 = mul_shift(64'd12 * stiff, i8, FB, sat);
			mmag = mul_shift(i8, t, FB, sat);
		end else begin
			mneg = d > one;
			mmag = (stiff * (mneg ? d - one : one - d)) / d;
		end
		// colour adhesion; touching pairs see unit gain
		if (r.touch) g = longint'(one);
		else if (it.c1 == COL_RED && it.c2 == COL_RED) g = gain_rr;
		else if ((it.c1 == COL_GREEN || it.c1 == COL_PGREEN) &&
				(it.c2 == COL_GREEN || it.c2 == COL_PGREEN)) g = gain_gg;
		else g = gain_rg;
		r.fx = axis_force(mmag, mneg, g, dx, sat);
		r.fy = axis_force(mmag, mneg, g, dy, sat);
		r.near = 1;
		r.sat = sat;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
		errors++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// input beat accepted: predict its result
	always @(posedge clk) begin
		pair_t it;
		taken <= pair_valid && pair_ready;
		if (arst_n && pair_valid && pair_ready) begin
			it = '{first_x, first_y, second_x, second_y, first_color, second_color};
			expected_forces.push_back(pair_force(it));
		end
	end

	// result monitor
	always @(posedge clk) begin
		force_res_t e;
		if (arst_n && force_valid && force_ready) begin
			if (expected_forces.size() == 0) begin
				report("unexpected beat", 0, 0);
			end else begin
				e = expected_forces.pop_front();
				if (force_x !== e.fx) report("force_x", force_x, e.fx);
				if (force_y !== e.fy) report("force_y", force_y, e.fy);
				if (touching !== e.touch) report("touching", touching, e.touch);
				if (in_range !== e.near) report("in_range", in_range, e.near);
				if (saturated !== e.sat) report("saturated", saturated, e.sat);
			end
		end
	end

	// pair driver
	always @(negedge clk) begin
		pair_t it;
		if (arst_n && (!pair_valid || taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				pair_valid <= 0;
			end else if (pending.size() != 0 && (quiet || $urandom_range(0, 5) != 0)) begin
				it = pending.pop_front();
				first_x <= it.x1;
				first_y <= it.y1;
				second_x <= it.x2;
				second_y <= it.y2;
				first_color <= it.c1;
				second_color <= it.c2;
				pair_valid <= 1;
			end else begin
				pair_valid <= 0;
				if (!quiet && pending.size() != 0) send_gap <= $urandom_range(0, 4);
			end
		end
	end

	// result receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (want_long_off && !long_done) begin
				force_ready <= 0;
				long_cnt <= long_cnt + 1;
				if (long_cnt == LONG_OFF) long_done <= 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				force_ready <= 0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				recv_gap <= $urandom_range(0, 4);
				force_ready <= 0;
			end else begin
				force_ready <= 1;
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 0;
		case (idx)
			REG_REGION: box_len = val;
			REG_K:      stiff = val[K_W-1:0];
			REG_RANGE:  cutoff = val[RANGE_W-1:0];
			REG_LJ:     lj_mode = val[0];
			REG_RR:     gain_rr = longint'($signed(val[GAIN_W-1:0]));
			REG_GG:     gain_gg = longint'($signed(val[GAIN_W-1:0]));
			REG_RG:     gain_rg = longint'($signed(val[GAIN_W-1:0]));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending.size() != 0 || pair_valid || expected_forces.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_pair(input logic [POS_W-1:0] x1, y1, x2, y2,
			input logic [COL_W-1:0] c1, c2);
		pair_t it;
		it = '{x1, y1, x2, y2, c1, c2};
		pending.push_back(it);
	endtask

	// handcrafted corners: zero, touching, unit distance, cutoff edge, wraps, colours
	task automatic directed();
		logic [POS_W-1:0] m, h;
		m = '1;
		h = box_len[POS_W-1:0] >> 1;
		add_pair(100, 100, 100, 100, 0, 0);
		add_pair(m, m, m, m, 3, 3);
		add_pair(1000, 1000, 1000, 1001, 0, 1);
		add_pair(70000, 5000, 5000, 5000, 1, 2);
		add_pair(65536, 0, 0, 0, 2, 2);
		add_pair(0, 65536, 0, 0, 0, 0);
		add_pair(0, 0, 65535, 0, 1, 1);
		add_pair(0, 0, 98303, 0, 0, 0);
		add_pair(0, 0, 98304, 0, 0, 0);
		add_pair(80000, 0, 0, 0, 0, 3);
		add_pair(80000, 80000, 0, 0, 2, 1);
		add_pair(h, 0, 0, 0, 1, 0);
		add_pair(0, h, 0, 0, 1, 0);
		add_pair(0, 0, h, 0, 0, 2);
		add_pair(box_len[POS_W-1:0] - 20000, 0, 20000, 0, 0, 0);
		add_pair(20000, 0, box_len[POS_W-1:0] - 20000, 0, 3, 1);
		add_pair(m, 0, 0, 0, 0, 0);
		add_pair(0, m, 0, m - 30000, 1, 1);
		add_pair(m, m, 0, 0, 2, 0);
		add_pair(3000, 3000, 3010, 2990, 3, 0);
		add_pair(40000, 0, 0, 40000, 3, 2);
	endtask

	task automatic random_pairs(input int n);
		logic [POS_W-1:0] x1, y1;
		int r;
		for (int i = 0; i < n; i++) begin
			x1 = (box_len != 0 && $urandom_range(0, 4) != 0) ? $urandom % box_len[31:0]
					: $urandom;
			y1 = (box_len != 0 && $urandom_range(0, 4) != 0) ? $urandom % box_len[31:0]
					: $urandom;
			case ($urandom_range(0, 3))
				0: r = 1 << 10;
				1: r = 1 << 16;
				2: r = 200000;
				default: r = int'(cutoff) + 8;
			endcase
			if ($urandom_range(0, 7) == 0)
				add_pair(x1, y1, $urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 3));
			else
				add_pair(x1, y1, x1 + $urandom_range(0, 2 * r) - r,
						y1 + $urandom_range(0, 2 * r) - r,
						$urandom_range(0, 3), $urandom_range(0, 3));
		end
	endtask

	task automatic random_config();
		case ($urandom_range(0, 4))
			0: write_reg(REG_REGION, RST_REGION);
			1: write_reg(REG_REGION, $urandom_range(1, 300000));
			2: write_reg(REG_REGION, '1);
			3: write_reg(REG_REGION, 0);
			default: write_reg(REG_REGION, $urandom);
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_K, 0);
			1: write_reg(REG_K, 24'hFFFFFF);
			default: write_reg(REG_K, $urandom_range(1, 300000));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(REG_RANGE, 0);
			1: write_reg(REG_RANGE, 20'hFFFFF);
			default: write_reg(REG_RANGE, $urandom_range(65536, 262144));
		endcase
		write_reg(REG_LJ, $urandom);
		write_reg(REG_RR, ($urandom_range(0, 3) == 0) ? 28'h0800000 : $urandom);
		write_reg(REG_GG, ($urandom_range(0, 3) == 0) ? 28'h07FFFFF : $urandom);
		write_reg(REG_RG, $urandom_range(0, 200000));
	endtask

	initial begin
		arst_n = 0;
		cfg_wen = 0;
		cfg_index = 0;
		cfg_data = 0;
		pair_valid = 0;
		force_ready = 0;
		{first_x, first_y, second_x, second_y} = '0;
		first_color = 0;
		second_color = 0;
		box_len = RST_REGION;
		stiff = RST_K;
		cutoff = RST_RANGE;
		lj_mode = 0;
		gain_rr = RST_GAIN;
		gain_gg = RST_GAIN;
		gain_rg = RST_GAIN;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// defaults, harmonic law
		directed();
		drain();
		// Lennard-Jones with extreme registers
		write_reg(REG_LJ, 1);
		write_reg(REG_K, 24'hFFFFFF);
		write_reg(REG_RANGE, 20'hFFFFF);
		write_reg(REG_RR, 28'h0800000);
		write_reg(REG_GG, 28'h07FFFFF);
		write_reg(REG_RG, 0);
		write_reg(REG_NONE, '1);
		directed();
		drain();
		write_reg(REG_REGION, '1);
		write_reg(REG_K, 0);
		write_reg(REG_RANGE, 0);
		write_reg(REG_LJ, 0);
		directed();
		random_pairs(60);
		drain();

		// random settings; the third one carries a long output stall
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			if (ph == 2) want_long_off = 1;
			if (ph == 7) quiet = 1;
			random_pairs(145);
			drain();
		end

		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
